[hdl/ffac_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffac_pkg
// Shared sizes, codes and types of the first-fit allocator.
// ----------------------------------------------------------------------------
package ffac_pkg;

  localparam int CELLS   = 128;
  localparam int ID_BITS = 16;

  // position counter, active count and compare widths
  localparam int PW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int MW = $clog2(CELLS + 1);
  localparam int NW = ((MW > 16) ? MW : 16) + 1;
  localparam int CW = (ID_BITS > 16) ? ID_BITS : 16;

  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_ERASE  = 2'd1;
  localparam logic [1:0] MODE_DEFRAG = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  typedef logic [ID_BITS-1:0] owner_t;

  typedef struct packed {
    logic shift;
    logic take_right;
    logic give_left;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[hdl/ffac_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffac_cell
// One memory cell: holds its owner id, rotates towards the head, or takes
// part in a compare-exchange with a neighbour during compaction.
// ----------------------------------------------------------------------------
module ffac_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ffac_pkg::cell_ctrl_t ctrl,
  input  wire ffac_pkg::owner_t    left_val,
  input  wire ffac_pkg::owner_t    right_val,
  output      ffac_pkg::owner_t    owner
);
  import ffac_pkg::*;

  // rotate, or move an owned cell down over a free one
  always_ff @(posedge clk) begin
    if (rst) begin
      owner <= '0;
    end else if (ctrl.shift) begin
      owner <= right_val;
    end else if (ctrl.take_right && owner == '0 && right_val != '0) begin
      owner <= right_val;
    end else if (ctrl.give_left && left_val == '0 && owner != '0) begin
      owner <= '0;
    end
  end

endmodule
`default_nettype wire

[hdl/first_fit_allocator_with_compaction_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_allocator_with_compaction_core
// First-fit cell allocator over a ring of cells, with erase and compaction.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  in      | in_valid in_stall mode operand        | request in
//  out     | out_valid out_stall status block_id   | response out
//  cfg     | cfg_we cfg_data                       | memory size write
//
// Allocate runs a scan pass and a mark pass of the ring; an allocate that
// finds no space runs only the scan pass. Erase runs one pass of the ring,
// and compaction one pass of odd-even exchanges; zero-size, exhausted and
// id-zero requests go straight to the response. The ring rotates by one
// cell per cycle. Reset clears every cell at once and sets the next id to one.
// The input stalls from acceptance until the request is finished; a new
// request is taken while a response waits in the output register, and the
// block holds in its response state while that register is still stalled.
// ----------------------------------------------------------------------------
module first_fit_allocator_with_compaction_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] operand,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  status,
  output      logic [15:0] block_id,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data
);
  import ffac_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_WRITE   = 3'd2;
  localparam logic [2:0] S_ERASE   = 3'd3;
  localparam logic [2:0] S_COMPACT = 3'd4;
  localparam logic [2:0] S_RESP    = 3'd5;

  localparam logic [PW-1:0] LAST = PW'(CELLS - 1);

  logic [2:0]       state;
  logic [PW-1:0]    cnt;
  logic [7:0]       memory_size;
  logic [ID_BITS:0] next_id;
  logic [15:0]      need;
  logic [CW-1:0]    erase_id;
  logic [MW-1:0]    run;
  logic [PW-1:0]    start;
  logic             found;
  logic             hit;
  logic [1:0]       resp_status;
  logic [15:0]      resp_id;

  owner_t     owner [CELLS];
  cell_ctrl_t ctrl  [CELLS];
  logic [CELLS-1:0] pair_en;

  logic [MW-1:0] m;
  logic          pos_act;
  owner_t        head;
  owner_t        head_new;
  logic          head_wr;
  logic [MW-1:0] run_inc;
  logic [NW-1:0] end_pos;
  logic          in_win;
  logic [CW-1:0] id_ext;
  logic [CW-1:0] head_ext;
  logic          ring_shift;

  // active range, clamped to the built row
  assign m       = (MW'(memory_size) > MW'(CELLS)) ? MW'(CELLS) : MW'(memory_size);
  assign pos_act = MW'(cnt) < m;
  assign head    = owner[0];
  assign run_inc = run + MW'(1);
  assign end_pos = NW'(start) + NW'(need);
  assign in_win  = (cnt >= start) && (NW'(cnt) < end_pos);
  assign id_ext  = CW'(next_id[ID_BITS-1:0]);
  assign head_ext = CW'(head);
  assign in_stall = (state != S_IDLE);
  assign ring_shift = (state == S_SCAN) || (state == S_WRITE) || (state == S_ERASE);

  // value written back into the tail of the ring
  always_comb begin
    head_wr  = 1'b0;
    head_new = head;
    if (state == S_WRITE && in_win) begin
      head_wr  = 1'b1;
      head_new = next_id[ID_BITS-1:0];
    end else if (state == S_ERASE && pos_act && head_ext == erase_id) begin
      head_wr  = 1'b1;
      head_new = '0;
    end
  end

  // pair enables for odd-even compaction
  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      pair_en[i] = (state == S_COMPACT) && (1'(i) == cnt[0]) &&
                   ((i + 1) < int'(m));
    end
  end

  // row of cells
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    owner_t lv;
    owner_t rv;
    logic   give;
    assign ctrl[g] = '{shift: ring_shift, take_right: pair_en[g], give_left: give};
    if (g == 0) begin : g_first
      assign give = 1'b0;
      assign lv = '0;
    end else begin : g_mid
      assign give = pair_en[g-1];
      assign lv = owner[g-1];
    end
    if (g == CELLS - 1) begin : g_tail
      assign rv = head_wr ? head_new : head;
    end else begin : g_body
      assign rv = owner[g+1];
    end
    ffac_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl[g]),
      .left_val  (lv),
      .right_val (rv),
      .owner     (owner[g])
    );
  end

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      memory_size <= 8'd128;
    end else if (cfg_we) begin
      memory_size <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      next_id   <= (ID_BITS+1)'(1);
      out_valid <= 1'b0;
      found     <= 1'b0;
      hit       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cnt   <= '0;
          run   <= '0;
          start <= '0;
          found <= 1'b0;
          hit   <= 1'b0;
          need  <= operand;
          erase_id <= CW'(operand);
          if (in_valid) begin
            unique case (mode)
              MODE_ALLOC: begin
                if (next_id[ID_BITS]) begin
                  resp_status <= ST_NOSPACE;
                  resp_id     <= '0;
                  state       <= S_RESP;
                end else if (operand == '0) begin
                  resp_status <= ST_OK;
                  resp_id     <= id_ext[15:0];
                  next_id     <= next_id + (ID_BITS+1)'(1);
                  state       <= S_RESP;
                end else begin
                  state <= S_SCAN;
                end
              end
              MODE_ERASE: begin
                if (operand == '0) begin
                  resp_status <= ST_ILLEGAL;
                  resp_id     <= '0;
                  state       <= S_RESP;
                end else begin
                  state <= S_ERASE;
                end
              end
              MODE_DEFRAG: state <= S_COMPACT;
              default:     state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          // track the current free run; stop on the first long enough
          if (!found && pos_act) begin
            if (head == '0) begin
              if (run == '0) begin
                start <= cnt;
              end
              run <= run_inc;
              if (NW'(run_inc) >= NW'(need)) begin
                found <= 1'b1;
              end
            end else begin
              run <= '0;
            end
          end
          cnt <= cnt + PW'(1);
          if (cnt == LAST) begin
            cnt <= '0;
            if (found || (!found && pos_act && head == '0 &&
                          NW'(run_inc) >= NW'(need))) begin
              state <= S_WRITE;
            end else begin
              resp_status <= ST_NOSPACE;
              resp_id     <= '0;
              state       <= S_RESP;
            end
          end
        end
        S_WRITE: begin
          cnt <= cnt + PW'(1);
          if (cnt == LAST) begin
            cnt         <= '0;
            resp_status <= ST_OK;
            resp_id     <= id_ext[15:0];
            next_id     <= next_id + (ID_BITS+1)'(1);
            state       <= S_RESP;
          end
        end
        S_ERASE: begin
          if (head_wr) begin
            hit <= 1'b1;
          end
          cnt <= cnt + PW'(1);
          if (cnt == LAST) begin
            cnt <= '0;
            if (hit || head_wr) begin
              state <= S_IDLE;
            end else begin
              resp_status <= ST_ILLEGAL;
              resp_id     <= '0;
              state       <= S_RESP;
            end
          end
        end
        S_COMPACT: begin
          cnt <= cnt + PW'(1);
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        S_RESP: begin
          // post once the output register is free
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status    <= resp_status;
            block_id  <= resp_id;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives allocate, erase and compaction requests into the first-fit allocator
// and checks every response against a behavioural model of the cell row.
// ----------------------------------------------------------------------------
module tb_top;
  import ffac_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_ALLOC;
  logic [15:0] operand = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] block_id;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_data = '0;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block_id;
  } reply_t;

  // model state
  owner_t      row_owner [CELLS];
  logic [31:0] id_next;
  logic [7:0]  mem_cells;
  reply_t      pending_replies [$];
  int          fail_count = 0;
  bit          hold_off = 1'b0;
  bit          burst_mode = 1'b1;

  localparam int DRAIN_CYCLES = 2 * CELLS + 20;

  first_fit_allocator_with_compaction_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .operand(operand),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .block_id(block_id), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int active_count();
    return (mem_cells > CELLS) ? CELLS : mem_cells;
  endfunction

  // compute the response of one request and advance the model
  function automatic void predict_request(logic [1:0] op, logic [15:0] arg);
    int     m;
    int     run;
    int     start;
    bit     found;
    bit     hit;
    int     wr;
    reply_t r;
    m = active_count();
    run = 0;
    start = 0;
    hit = 1'b0;
    wr = 0;
    case (op)
      MODE_ALLOC: begin
        found = (arg == 0);
        if (id_next > (32'd1 << ID_BITS) - 1) begin
          r = '{ST_NOSPACE, 16'd0};
        end else begin
          for (int i = 0; i < m && !found; i++) begin
            if (row_owner[i] == '0) begin
              if (run == 0) start = i;
              run++;
              if (run >= arg) found = 1'b1;
            end else begin
              run = 0;
            end
          end
          if (!found) begin
            r = '{ST_NOSPACE, 16'd0};
          end else begin
            for (int i = 0; i < arg; i++) row_owner[start + i] = owner_t'(id_next);
            r = '{ST_OK, id_next[15:0]};
            id_next++;
          end
        end
        pending_replies.push_back(r);
      end
      MODE_ERASE: begin
        if (arg != 0) begin
          for (int i = 0; i < m; i++) begin
            if (row_owner[i] == owner_t'(arg)) begin
              row_owner[i] = '0;
              hit = 1'b1;
            end
          end
        end
        if (!hit) pending_replies.push_back('{ST_ILLEGAL, 16'd0});
      end
      MODE_DEFRAG: begin
        for (int i = 0; i < m; i++) begin
          if (row_owner[i] != '0) begin
            row_owner[wr] = row_owner[i];
            wr++;
          end
        end
        for (int i = wr; i < m; i++) row_owner[i] = '0;
      end
      default: ;
    endcase
  endfunction

  // present one request and hold it until accepted; drop valid only for a gap
  task automatic send_request(logic [1:0] op, logic [15:0] arg);
    int gap;
    gap = 0;
    if (!burst_mode) begin
      gap = $urandom_range(0, 6);
    end else if ($urandom_range(0, 15) == 0) begin
      gap = $urandom_range(1, 20);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    operand  <= arg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(op, arg);
    @(negedge clk);
  endtask

  // wait for all responses, then let the block settle before a register write
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_size(logic [7:0] v);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    mem_cells = v;
  endtask

  // pick an id that likely exists, sometimes a stale or zero one
  function automatic logic [15:0] pick_id();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'd0;
    if (k == 1) return 16'($urandom);
    if (id_next <= 1) return 16'd1;
    return 16'($urandom_range(1, id_next - 1));
  endfunction

  task automatic random_mix(int n, int max_size);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50)      send_request(MODE_ALLOC, 16'($urandom_range(0, max_size)));
      else if (k < 85) send_request(MODE_ERASE, pick_id());
      else if (k < 97) send_request(MODE_DEFRAG, 16'($urandom));
      else             send_request(2'd3, 16'($urandom));
    end
  endtask

  task automatic test_directed();
    send_request(MODE_ALLOC, 16'd0);
    send_request(MODE_ALLOC, 16'd1);
    send_request(MODE_ALLOC, 16'd10);
    send_request(MODE_ALLOC, 16'd5);
    send_request(MODE_ALLOC, 16'hFFFF);
    send_request(MODE_ALLOC, 16'd129);
    send_request(MODE_ERASE, 16'd0);
    send_request(MODE_ERASE, 16'hFFFF);
    send_request(MODE_ERASE, 16'd3);
    send_request(MODE_ERASE, 16'd3);
    send_request(2'd3, 16'hAAAA);
    send_request(MODE_DEFRAG, 16'h5555);
    send_request(MODE_ALLOC, 16'd112);
    send_request(MODE_ALLOC, 16'd1);
    send_request(MODE_ERASE, 16'd2);
    send_request(MODE_ALLOC, 16'd1);
    send_request(MODE_ALLOC, 16'd2);
  endtask

  // shrink and grow the active range, including zero and the maximum
  task automatic test_memory_size();
    write_size(8'd0);
    send_request(MODE_ALLOC, 16'd1);
    send_request(MODE_ALLOC, 16'd0);
    send_request(MODE_ERASE, 16'd1);
    send_request(MODE_DEFRAG, 16'd0);
    write_size(8'd255);
    random_mix(40, 40);
    write_size(8'd1);
    random_mix(20, 2);
    write_size(8'd20);
    random_mix(40, 8);
    write_size(8'd128);
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 6; i++) send_request(MODE_ALLOC, 16'd0);
      end
    join
  endtask

  task automatic test_random();
    for (int p = 0; p < 6; p++) begin
      burst_mode = p[0];
      random_mix(50, (p < 4) ? 12 : 64);
      if (p == 2) write_size(8'($urandom_range(1, 128)));
      if (p == 3) write_size(8'd128);
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else          out_stall <= ($urandom_range(0, 3) == 0);
  end

  // compare each response with the oldest expectation
  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected response status=%0d block_id=%0d", status, block_id);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status) begin
          $error("status expected %0d got %0d", want.status, status);
          fail_count++;
        end
        if (block_id !== want.block_id) begin
          $error("block_id expected %0d got %0d", want.block_id, block_id);
          fail_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) row_owner[i] = '0;
    id_next   = 1;
    mem_cells = 8'd128;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_memory_size();
    test_random();
    wait_idle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
hdl/ffac_pkg.sv
hdl/ffac_cell.sv
hdl/first_fit_allocator_with_compaction_core.sv
bench/tb_top.sv
